// ===== rtl/core/lop_pkg.sv =====
package lop_pkg;

	localparam int COORD_W   = 24;
	localparam int RADIUS_W  = 24;
	localparam int COUNT_W   = 11;
	localparam int EXP_DEPTH = 256;
	localparam int EXP_W     = 16;
	localparam int WSUM_W    = 64;
	localparam int DEN_W     = 48;
	localparam int QUO_W     = 40;
	localparam int STEP_W    = 7;

	localparam logic [COUNT_W-1:0]  MAX_NEIGHBOURS = 11'd1024;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET   = 24'd52429;

	// Division lengths (quotient bits) for the three uses of the divider
	localparam logic [STEP_W-1:0] STEPS_IDX    = 7'd8;
	localparam logic [STEP_W-1:0] STEPS_WEIGHT = 7'd40;
	localparam logic [STEP_W-1:0] STEPS_OUT    = 7'd24;

	// Request and response of the shared divider
	typedef struct packed {
		logic                start;
		logic [63:0]         num;
		logic [DEN_W-1:0]    den;
		logic [STEP_W-1:0]   steps;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic                ovf;
		logic [QUO_W-1:0]    quo;
	} div_rsp_t;

	// Build the exp(-16 i / depth) samples in unsigned Q0.16
	function automatic logic [EXP_DEPTH-1:0][EXP_W-1:0] build_exp();
		logic [EXP_DEPTH-1:0][EXP_W-1:0] tab;
		logic [63:0]        x;
		logic [63:0]        term;
		logic signed [63:0] base;
		logic [63:0]        e;
		logic [63:0]        v;
		x    = (64'd16 << 32) / EXP_DEPTH;
		term = 64'd1 << 32;
		base = 64'sd1 <<< 32;
		e    = 64'd1 << 32;
		for (int k = 1; k <= 24; k++) begin
			term = ((term * x) >> 32) / 64'(k);
			if (k % 2 == 1) begin
				base = base - $signed(term);
			end else begin
				base = base + $signed(term);
			end
		end
		if (base < 0) begin
			base = 0;
		end
		for (int i = 0; i < EXP_DEPTH; i++) begin
			v = (e + (64'd1 << 15)) >> 16;
			tab[i] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
			e = (e * $unsigned(base) + (64'd1 << 31)) >> 32;
		end
		return tab;
	endfunction

	localparam logic [EXP_DEPTH-1:0][EXP_W-1:0] EXP_TAB = build_exp();

endpackage

// ===== rtl/core/lop_mul.sv =====
module lop_mul import lop_pkg::*; (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p_s1
);

	// Register the unsigned product
	always_ff @(posedge clk) begin
		p_s1 <= {32'b0, a} * {32'b0, b};
	end

endmodule

// ===== rtl/core/lop_div.sv =====
module lop_div import lop_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                busy_q;
	logic                done_q;
	logic                ovf_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [DEN_W-1:0]    rem_q;
	logic [63:0]         num_q;
	logic [DEN_W-1:0]    den_q;
	logic [QUO_W-1:0]    quo_q;

	logic [63:0]         num_hi;
	logic [63:0]         num_lo;
	logic                pre_ovf;
	logic [DEN_W:0]      trial;
	logic [DEN_W:0]      diff;
	logic                ge;

	// Split the numerator: upper part seeds the remainder, lower part is shifted in
	always_comb begin
		num_hi  = req.num >> req.steps;
		num_lo  = req.num << (7'd64 - req.steps);
		pre_ovf = num_hi >= {16'b0, req.den};
		trial   = {rem_q, num_q[63]};
		diff    = trial - {1'b0, den_q};
		ge      = trial >= {1'b0, den_q};
	end

	// Control: one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (pre_ovf) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= req.steps;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: restoring division step
	always_ff @(posedge clk) begin
		if (req.start) begin
			ovf_q <= pre_ovf;
			rem_q <= num_hi[DEN_W-1:0];
			num_q <= num_lo;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[62:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign rsp.quo  = quo_q;

endmodule

// ===== rtl/core/lop_weighted_point_projection_unit.sv =====
// Weighted point projection unit.
// Input channel (in_valid/in_ready): one word per candidate, carrying the
// query point, the candidate point and first/last flags. The query point is
// latched and the sums cleared on a first word. Output channel
// (out_valid/out_ready): one word after each last candidate, the weighted
// mean of the kept candidates (the held query point when their weight sum is
// zero), their count and a no-neighbours flag. The user writes the radius
// register through cfg_we/cfg_wdata only while idle; the block does not
// enforce it. Flow: one candidate at a time through a shared 32x32 multiplier
// and a shared one-bit-per-cycle divider. A candidate is rejected by the box
// test, rejected by the sphere test, or kept; a kept one runs the index
// division (skipped when r is not below h) and the weight division. A last
// word with a nonzero weight sum adds the three output divisions, and every
// last word then loads the output register. in_ready is high only while the
// sequencer is idle. A finished word waits in the output register while the
// receiver stalls; the next candidate is still taken, and the sequencer holds
// only when a second result is ready before the first is taken.
// Reset clears control, the sums, the held query point and sets the radius
// to 52429 (0.05 in Q4.20). No clearing pass is needed.
module lop_weighted_point_projection_unit import lop_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [RADIUS_W-1:0]        cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [COORD_W-1:0]  query_x,
	input  logic signed [COORD_W-1:0]  query_y,
	input  logic signed [COORD_W-1:0]  query_z,
	input  logic signed [COORD_W-1:0]  cand_x,
	input  logic signed [COORD_W-1:0]  cand_y,
	input  logic signed [COORD_W-1:0]  cand_z,
	input  logic                       first_of_query,
	input  logic                       last_of_query,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [COORD_W-1:0]  out_x,
	output logic signed [COORD_W-1:0]  out_y,
	output logic signed [COORD_W-1:0]  out_z,
	output logic [COUNT_W-1:0]         kept_count,
	output logic                       no_neighbours
);

	typedef enum logic [17:0] {
		S_IDLE   = 18'h00001,
		S_DIFF   = 18'h00002,
		S_BOX    = 18'h00004,
		S_SQ     = 18'h00008,
		S_CHK    = 18'h00010,
		S_IDXW   = 18'h00020,
		S_WSTART = 18'h00040,
		S_WW     = 18'h00080,
		S_MLO    = 18'h00100,
		S_MHI    = 18'h00200,
		S_MSUM   = 18'h00400,
		S_ACC    = 18'h00800,
		S_WACC   = 18'h01000,
		S_FIN    = 18'h02000,
		S_FPREP  = 18'h04000,
		S_FDIV   = 18'h08000,
		S_FW     = 18'h10000,
		S_OUT    = 18'h20000
	} state_t;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
	localparam logic signed [WSUM_W-1:0]  WSUM_MAX  = 64'sh7FFFFFFFFFFFFFFF;
	localparam logic signed [WSUM_W-1:0]  WSUM_MIN  = 64'sh8000000000000000;

	state_t                      state_q;
	logic [RADIUS_W-1:0]         radius_q;
	logic signed [COORD_W-1:0]   held_q [0:2];
	logic signed [WSUM_W-1:0]    wsum_q [0:2];
	logic [DEN_W-1:0]            den_q;
	logic [COUNT_W-1:0]          cnt_q;

	logic signed [COORD_W-1:0]   cand_q [0:2];
	logic [COORD_W-1:0]          candm_q [0:2];
	logic [COORD_W:0]            ad_q [0:2];
	logic                        last_q;
	logic [2:0]                  sq_cnt_q;
	logic [1:0]                  axis_q;
	logic [47:0]                 h2_q;
	logic [49:0]                 d2_q;
	logic [25:0]                 r_q;
	logic [51:0]                 r2_q;
	logic [EXP_W-1:0]            g_q;
	logic [QUO_W-1:0]            w_q;
	logic [55:0]                 plo_q;
	logic [63:0]                 prod_q;
	logic [63:0]                 mag_q;
	logic                        neg_q;
	logic signed [COORD_W-1:0]   res_q [0:2];

	logic                        out_valid_q;
	logic signed [COORD_W-1:0]   out_q [0:2];
	logic [COUNT_W-1:0]          out_cnt_q;
	logic                        out_none_q;

	logic [RADIUS_W-1:0]         h_w;
	logic [31:0]                 mul_a;
	logic [31:0]                 mul_b;
	logic [63:0]                 mul_p;
	div_req_t                    div_req;
	div_rsp_t                    div_rsp;
	logic                        accept;
	logic                        out_free;
	logic [COORD_W:0]            dsub [0:2];
	logic [26:0]                 rsum;
	logic                        box_in;
	logic signed [WSUM_W:0]      acc_sum;
	logic [DEN_W:0]              den_sum;
	logic [COORD_W-1:0]          q_w;
	logic signed [COORD_W-1:0]   res_w;

	assign h_w      = (radius_q == '0) ? 24'd1 : radius_q;
	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || out_ready;

	lop_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.p_s1 (mul_p)
	);

	lop_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Differences to the held point, the summed distance and the box test
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			dsub[j] = {cand_q[j][COORD_W-1], cand_q[j]} - {held_q[j][COORD_W-1], held_q[j]};
		end
		rsum   = {2'b0, ad_q[0]} + {2'b0, ad_q[1]} + {2'b0, ad_q[2]};
		box_in = (ad_q[0] <= {1'b0, h_w}) && (ad_q[1] <= {1'b0, h_w}) &&
		         (ad_q[2] <= {1'b0, h_w});
	end

	// Select the multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_SQ) begin
			unique case (sq_cnt_q)
				3'd0: begin
					mul_a = {8'b0, h_w};
					mul_b = {8'b0, h_w};
				end
				3'd1: begin
					mul_a = {7'b0, ad_q[0]};
					mul_b = {7'b0, ad_q[0]};
				end
				3'd2: begin
					mul_a = {7'b0, ad_q[1]};
					mul_b = {7'b0, ad_q[1]};
				end
				3'd3: begin
					mul_a = {7'b0, ad_q[2]};
					mul_b = {7'b0, ad_q[2]};
				end
				3'd4: begin
					mul_a = {6'b0, r_q};
					mul_b = {6'b0, r_q};
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end else if (state_q == S_MLO) begin
			mul_a = w_q[31:0];
			mul_b = {8'b0, candm_q[axis_q]};
		end else if (state_q == S_MHI) begin
			mul_a = {24'b0, w_q[39:32]};
			mul_b = {8'b0, candm_q[axis_q]};
		end
	end

	// Drive the divider for the table index, the weight and the outputs
	always_comb begin
		div_req = '0;
		if (state_q == S_CHK && d2_q <= {2'b0, h2_q} && r2_q < {4'b0, h2_q}) begin
			div_req.start = 1'b1;
			div_req.num   = {4'b0, r2_q, 8'b0};
			div_req.den   = h2_q;
			div_req.steps = STEPS_IDX;
		end else if (state_q == S_WSTART) begin
			div_req.start = 1'b1;
			div_req.num   = {24'b0, g_q, 24'b0};
			div_req.den   = {22'b0, r_q};
			div_req.steps = STEPS_WEIGHT;
		end else if (state_q == S_FDIV) begin
			div_req.start = 1'b1;
			div_req.num   = mag_q + {17'b0, den_q[DEN_W-1:1]};
			div_req.den   = den_q;
			div_req.steps = STEPS_OUT;
		end
	end

	// Saturating sums and the rounded output coordinate
	always_comb begin
		if (cand_q[axis_q] < 0) begin
			acc_sum = {wsum_q[axis_q][WSUM_W-1], wsum_q[axis_q]} - {1'b0, prod_q};
		end else begin
			acc_sum = {wsum_q[axis_q][WSUM_W-1], wsum_q[axis_q]} + {1'b0, prod_q};
		end
		den_sum = {1'b0, den_q} + {9'b0, w_q};
		q_w     = div_rsp.quo[COORD_W-1:0];
		if (div_rsp.ovf) begin
			res_w = neg_q ? COORD_MIN : COORD_MAX;
		end else if (neg_q) begin
			res_w = (q_w > 24'h800000) ? COORD_MIN : $signed(~q_w + 24'd1);
		end else begin
			res_w = (q_w > 24'h7FFFFF) ? COORD_MAX : $signed(q_w);
		end
	end

	// Hold the radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// Sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sq_cnt_q <= '0;
			axis_q   <= '0;
			last_q   <= 1'b0;
			den_q    <= '0;
			cnt_q    <= '0;
			for (int j = 0; j < 3; j++) begin
				held_q[j] <= '0;
				wsum_q[j] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q  <= last_of_query;
						state_q <= S_DIFF;
						if (first_of_query) begin
							held_q[0] <= query_x;
							held_q[1] <= query_y;
							held_q[2] <= query_z;
							den_q     <= '0;
							cnt_q     <= '0;
							for (int j = 0; j < 3; j++) begin
								wsum_q[j] <= '0;
							end
						end
					end
				end
				S_DIFF: begin
					state_q <= S_BOX;
				end
				S_BOX: begin
					sq_cnt_q <= '0;
					state_q  <= box_in ? S_SQ : S_FIN;
				end
				S_SQ: begin
					sq_cnt_q <= sq_cnt_q + 3'd1;
					if (sq_cnt_q == 3'd5) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (d2_q > {2'b0, h2_q}) begin
						state_q <= S_FIN;
					end else if (r2_q < {4'b0, h2_q}) begin
						state_q <= S_IDXW;
					end else begin
						state_q <= S_WSTART;
					end
				end
				S_IDXW: begin
					if (div_rsp.done) begin
						state_q <= S_WSTART;
					end
				end
				S_WSTART: begin
					state_q <= S_WW;
				end
				S_WW: begin
					if (div_rsp.done) begin
						axis_q  <= '0;
						state_q <= S_MLO;
					end
				end
				S_MLO: begin
					state_q <= S_MHI;
				end
				S_MHI: begin
					state_q <= S_MSUM;
				end
				S_MSUM: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (acc_sum[WSUM_W] != acc_sum[WSUM_W-1]) begin
						wsum_q[axis_q] <= acc_sum[WSUM_W] ? WSUM_MIN : WSUM_MAX;
					end else begin
						wsum_q[axis_q] <= acc_sum[WSUM_W-1:0];
					end
					axis_q  <= axis_q + 2'd1;
					state_q <= (axis_q == 2'd2) ? S_WACC : S_MLO;
				end
				S_WACC: begin
					den_q <= den_sum[DEN_W] ? {DEN_W{1'b1}} : den_sum[DEN_W-1:0];
					if (cnt_q < MAX_NEIGHBOURS) begin
						cnt_q <= cnt_q + 11'd1;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					axis_q <= '0;
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (den_q == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_FPREP;
					end
				end
				S_FPREP: begin
					state_q <= S_FDIV;
				end
				S_FDIV: begin
					state_q <= S_FW;
				end
				S_FW: begin
					if (div_rsp.done) begin
						axis_q  <= axis_q + 2'd1;
						state_q <= (axis_q == 2'd2) ? S_OUT : S_FPREP;
					end
				end
				S_OUT: begin
					if (out_free) begin
						den_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_IDLE;
						for (int j = 0; j < 3; j++) begin
							wsum_q[j] <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers along the sequence
	always_ff @(posedge clk) begin
		if (accept) begin
			cand_q[0] <= cand_x;
			cand_q[1] <= cand_y;
			cand_q[2] <= cand_z;
		end
		if (state_q == S_DIFF) begin
			for (int j = 0; j < 3; j++) begin
				ad_q[j]    <= dsub[j][COORD_W] ? (~dsub[j] + 25'd1) : dsub[j];
				candm_q[j] <= cand_q[j][COORD_W-1] ? (~cand_q[j] + 24'd1) : cand_q[j];
			end
		end
		if (state_q == S_BOX) begin
			r_q  <= (rsum == '0) ? 26'd1 : rsum[25:0];
			d2_q <= '0;
		end
		if (state_q == S_SQ) begin
			unique case (sq_cnt_q)
				3'd1: h2_q <= mul_p[47:0];
				3'd2, 3'd3, 3'd4: d2_q <= d2_q + {1'b0, mul_p[48:0]};
				3'd5: r2_q <= mul_p[51:0];
				default: ;
			endcase
		end
		if (state_q == S_CHK) begin
			g_q <= '0;
		end
		if (state_q == S_IDXW && div_rsp.done) begin
			g_q <= EXP_TAB[div_rsp.quo[7:0]];
		end
		if (state_q == S_WW && div_rsp.done) begin
			w_q <= div_rsp.quo;
		end
		if (state_q == S_MHI) begin
			plo_q <= mul_p[55:0];
		end
		if (state_q == S_MSUM) begin
			prod_q <= {8'b0, plo_q} + {mul_p[31:0], 32'b0};
		end
		if (state_q == S_FIN) begin
			for (int j = 0; j < 3; j++) begin
				res_q[j] <= held_q[j];
			end
		end
		if (state_q == S_FPREP) begin
			neg_q <= wsum_q[axis_q][WSUM_W-1];
			mag_q <= wsum_q[axis_q][WSUM_W-1] ? (~wsum_q[axis_q] + 64'd1) : wsum_q[axis_q];
		end
		if (state_q == S_FW && div_rsp.done) begin
			res_q[axis_q] <= res_w;
		end
	end

	// Output register: load a finished word, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			for (int j = 0; j < 3; j++) begin
				out_q[j] <= res_q[j];
			end
			out_cnt_q  <= cnt_q;
			out_none_q <= (cnt_q == '0);
		end
	end

	assign out_valid     = out_valid_q;
	assign out_x         = out_q[0];
	assign out_y         = out_q[1];
	assign out_z         = out_q[2];
	assign kept_count    = out_cnt_q;
	assign no_neighbours = out_none_q;

endmodule

// ===== rtl/core/lop_port_checker.sv =====
module lop_port_checker import lop_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [COORD_W-1:0] out_x,
	input logic [COUNT_W-1:0]        kept_count,
	input logic                      no_neighbours
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(kept_count))
		else $error("result word changed while stalled");

	// The no-neighbours flag agrees with the count
	a_none_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (no_neighbours == (kept_count == '0)))
		else $error("no_neighbours disagrees with kept_count");

	// The count never passes its ceiling
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kept_count <= MAX_NEIGHBOURS)
		else $error("kept_count above ceiling");

	// One candidate at a time: busy after each accepted word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

endmodule

bind lop_weighted_point_projection_unit lop_port_checker u_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.out_x         (out_x),
	.kept_count    (kept_count),
	.no_neighbours (no_neighbours)
);

// ===== sim/tb_lop_weighted_point_projection_unit.sv =====
`timescale 1ns / 100ps

module tb_lop_weighted_point_projection_unit;
	import lop_pkg::*;

	localparam int  CYCLE_LIMIT = 2000000;
	localparam int  SETTLE      = 300;
	localparam longint SMAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam longint SMIN     = -SMAX - 1;
	localparam longint unsigned WTOT_MAX = (64'd1 << 48) - 1;

	typedef struct packed {
		logic signed [COORD_W-1:0] qx, qy, qz;
		logic signed [COORD_W-1:0] cx, cy, cz;
		logic                      first, last;
	} cand_word_t;

	typedef struct packed {
		logic [COORD_W-1:0] px, py, pz;
		logic [COUNT_W-1:0] kept;
		logic               none;
	} proj_point_t;

	// Running projection of the block, with its own copy of state and radius
	class projection_predictor;
		logic [15:0]       gauss_lut [EXP_DEPTH];
		logic [RADIUS_W-1:0] radius;
		longint            held_q [3];
		longint            wsum [3];
		longint unsigned   wtot;
		int                kept_n;
		proj_point_t       expected_points [$];
		int                errors;

		function new();
			longint unsigned x, term, e, v;
			longint          base;
			x = (64'd16 << 32) / EXP_DEPTH;
			term = 64'd1 << 32;
			base = 64'sd1 <<< 32;
			e = 64'd1 << 32;
			for (int k = 1; k <= 24; k++) begin
				term = ((term * x) >> 32) / k;
				if (k % 2) base -= longint'(term);
				else base += longint'(term);
			end
			if (base < 0) base = 0;
			for (int i = 0; i < EXP_DEPTH; i++) begin
				v = (e + (64'd1 << 15)) >> 16;
				gauss_lut[i] = (v > 65535) ? 16'hFFFF : v[15:0];
				e = (e * longint'(base) + (64'd1 << 31)) >> 32;
			end
			radius = RADIUS_RESET;
			errors = 0;
			foreach (held_q[j]) held_q[j] = 0;
			clear_sums();
		endfunction

		function void clear_sums();
			foreach (wsum[j]) wsum[j] = 0;
			wtot = 0;
			kept_n = 0;
		endfunction

		function longint sat_add(longint a, longint b);
			if (b > 0 && a > SMAX - b) return SMAX;
			if (b < 0 && a < SMIN - b) return SMIN;
			return a + b;
		endfunction

		function logic [COORD_W-1:0] mean_coord(longint num, longint unsigned den);
			longint unsigned mg, q;
			longint          hi, v;
			hi = (64'sd1 <<< (COORD_W - 1)) - 1;
			mg = (num < 0) ? -num : num;
			q = (mg + den / 2) / den;
			if (num < 0) v = (q > hi + 1) ? -hi - 1 : -longint'(q);
			else v = (q > hi) ? hi : longint'(q);
			return v[COORD_W-1:0];
		endfunction

		// Fold one accepted candidate into the sums; queue a point on last
		function void take_word(cand_word_t it);
			longint unsigned h, h2, d2, r, r2, g, w, m, idx;
			longint unsigned ad [3];
			longint          c [3], diff, p;
			bit              keep;
			proj_point_t     pt;
			h = (radius != 0) ? radius : 1;
			h2 = h * h;
			d2 = 0;
			r = 0;
			keep = 1;
			if (it.first) begin
				held_q[0] = it.qx; held_q[1] = it.qy; held_q[2] = it.qz;
				clear_sums();
			end
			c[0] = it.cx; c[1] = it.cy; c[2] = it.cz;
			for (int j = 0; j < 3; j++) begin
				diff = c[j] - held_q[j];
				ad[j] = (diff < 0) ? -diff : diff;
				if (ad[j] > h) keep = 0;
			end
			if (keep) begin
				for (int j = 0; j < 3; j++) begin
					d2 += ad[j] * ad[j];
					r += ad[j];
				end
				keep = (d2 <= h2);
			end
			if (keep) begin
				g = 0;
				if (r == 0) r = 1;
				r2 = r * r;
				if (r2 < h2) begin
					idx = (r2 * EXP_DEPTH) / h2;
					if (idx < EXP_DEPTH) g = gauss_lut[idx];
				end
				w = (g << 24) / r;
				for (int j = 0; j < 3; j++) begin
					m = (c[j] < 0) ? -c[j] : c[j];
					if (m != 0 && w > longint'(SMAX) / m) p = SMAX;
					else p = longint'(w * m);
					if (c[j] < 0) p = -p;
					wsum[j] = sat_add(wsum[j], p);
				end
				wtot = (wtot > WTOT_MAX - w) ? WTOT_MAX : wtot + w;
				if (kept_n < MAX_NEIGHBOURS) kept_n++;
			end
			if (!it.last) return;
			if (wtot == 0) begin
				pt.px = held_q[0][COORD_W-1:0];
				pt.py = held_q[1][COORD_W-1:0];
				pt.pz = held_q[2][COORD_W-1:0];
			end else begin
				pt.px = mean_coord(wsum[0], wtot);
				pt.py = mean_coord(wsum[1], wtot);
				pt.pz = mean_coord(wsum[2], wtot);
			end
			pt.kept = kept_n[COUNT_W-1:0];
			pt.none = (kept_n == 0);
			expected_points.push_back(pt);
			clear_sums();
		endfunction

		function void check_word(proj_point_t got);
			proj_point_t exp_pt;
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected point x=%h y=%h z=%h", $time, got.px, got.py, got.pz);
				errors++;
				return;
			end
			exp_pt = expected_points.pop_front();
			if (got.px !== exp_pt.px) begin
				$display("%0t: out_x expected %h actual %h", $time, exp_pt.px, got.px);
				errors++;
			end
			if (got.py !== exp_pt.py) begin
				$display("%0t: out_y expected %h actual %h", $time, exp_pt.py, got.py);
				errors++;
			end
			if (got.pz !== exp_pt.pz) begin
				$display("%0t: out_z expected %h actual %h", $time, exp_pt.pz, got.pz);
				errors++;
			end
			if (got.kept !== exp_pt.kept) begin
				$display("%0t: kept_count expected %0d actual %0d", $time, exp_pt.kept, got.kept);
				errors++;
			end
			if (got.none !== exp_pt.none) begin
				$display("%0t: no_neighbours expected %b actual %b", $time, exp_pt.none, got.none);
				errors++;
			end
		endfunction
	endclass

	logic                      clk, arst_n, cfg_we, in_valid, in_ready, out_valid, out_ready;
	logic [RADIUS_W-1:0]       cfg_wdata;
	logic signed [COORD_W-1:0] query_x, query_y, query_z, cand_x, cand_y, cand_z;
	logic signed [COORD_W-1:0] out_x, out_y, out_z;
	logic                      first_of_query, last_of_query, no_neighbours;
	logic [COUNT_W-1:0]        kept_count;

	projection_predictor pred = new();
	bit  calm;
	bit  hold_req;
	int  cycles;

	lop_weighted_point_projection_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.query_x(query_x), .query_y(query_y), .query_z(query_z),
		.cand_x(cand_x), .cand_y(cand_y), .cand_z(cand_z),
		.first_of_query(first_of_query), .last_of_query(last_of_query),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.kept_count(kept_count), .no_neighbours(no_neighbours)
	);

	initial begin
		clk = 0; arst_n = 0; cfg_we = 0; cfg_wdata = '0; in_valid = 0; out_ready = 0;
		query_x = '0; query_y = '0; query_z = '0;
		cand_x = '0; cand_y = '0; cand_z = '0;
		first_of_query = 0; last_of_query = 0;
	end

	always #5 clk = ~clk;

	// Abort on a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: random stalls, or one long hold on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 0;
				repeat (2000) @(posedge clk);
			end else begin
				gap = calm ? 0 : $urandom_range(0, 4);
				if (gap > 0) begin
					out_ready <= 0;
					repeat (gap) @(posedge clk);
				end
			end
			out_ready <= 1;
			do @(posedge clk); while (!out_valid);
			pred.check_word({out_x, out_y, out_z, kept_count, no_neighbours});
		end
	end

	// Offer one word; return at the edge where it is taken
	task automatic send_word(cand_word_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		{query_x, query_y, query_z, cand_x, cand_y, cand_z, first_of_query, last_of_query} <= it;
		do @(posedge clk); while (!in_ready);
		pred.take_word(it);
	endtask

	// Drop valid and wait for every queued point, then let the block settle
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pred.expected_points.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_radius(logic [RADIUS_W-1:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		pred.radius = v;
		@(posedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
		if (v > 8388607) return 24'sh7FFFFF;
		if (v < -8388608) return 24'sh800000;
		return v[COORD_W-1:0];
	endfunction

	// Candidate around the query: near, on the radius edge, on the query, within the radius box, or anywhere
	function automatic cand_word_t make_cand(cand_word_t base, int kind);
		longint h, o [3];
		cand_word_t it;
		h = (pred.radius != 0) ? pred.radius : 1;
		it = base;
		for (int j = 0; j < 3; j++) o[j] = longint'($urandom_range(0, 2 * h)) - h;
		case (kind)
			0: begin o[0] = o[0] / 2; o[1] = o[1] / 2; o[2] = o[2] / 2; end
			1: begin o[0] = ($urandom_range(0, 1)) ? h : -h; o[1] = 0; o[2] = 0; end
			3: begin o[0] = 0; o[1] = 0; o[2] = 0; end
			default: ;
		endcase
		if (kind == 2) begin
			it.cx = 24'($urandom); it.cy = 24'($urandom); it.cz = 24'($urandom);
		end else begin
			it.cx = clamp_coord(longint'(base.qx) + o[0]);
			it.cy = clamp_coord(longint'(base.qy) + o[1]);
			it.cz = clamp_coord(longint'(base.qz) + o[2]);
		end
		return it;
	endfunction

	// One query: first word, some candidates, last word
	task automatic run_query(int len);
		cand_word_t base, it;
		base.qx = 24'($urandom); base.qy = 24'($urandom); base.qz = 24'($urandom);
		for (int i = 0; i < len; i++) begin
			it = make_cand(base, $urandom_range(0, 5));
			it.first = (i == 0);
			it.last = (i == len - 1);
			if (i != 0) begin
				it.qx = 24'($urandom); it.qy = 24'($urandom); it.qz = 24'($urandom);
			end
			send_word(it);
		end
	endtask

	task automatic run_random(int items);
		int sent, len;
		cand_word_t it;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 99) < 15) begin
				it.qx = 24'($urandom); it.qy = 24'($urandom); it.qz = 24'($urandom);
				it.cx = 24'($urandom); it.cy = 24'($urandom); it.cz = 24'($urandom);
				it.first = 1'($urandom_range(0, 1));
				it.last = 1'($urandom_range(0, 1));
				send_word(it);
				sent++;
			end else begin
				len = $urandom_range(1, 6);
				run_query(len);
				sent += len;
			end
			if ($urandom_range(0, 19) == 0) calm = ~calm;
		end
		calm = 0;
	endtask

	initial begin
		cand_word_t it;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: held query from reset, without a first flag
		it = '0;
		it.qx = 24'sh7FFFFF; it.cx = 24'sd100; it.last = 1;
		send_word(it);
		// Extremes of the coordinates, far apart: no neighbours
		it = '0;
		it.qx = 24'sh7FFFFF; it.qy = 24'sh800000; it.qz = 24'sh7FFFFF;
		it.cx = 24'sh800000; it.cy = 24'sh7FFFFF; it.cz = 24'sh800000;
		it.first = 1; it.last = 1;
		send_word(it);
		// Candidate on the query, on the radius edge (zero weight), then a mix
		it = '0;
		it.qx = 24'sd1000; it.qy = -24'sd2000; it.qz = 24'sd3;
		it.cx = 24'sd1000; it.cy = -24'sd2000; it.cz = 24'sd3; it.first = 1;
		send_word(it);
		it.first = 0; it.cx = 24'sd1000 + RADIUS_RESET;
		send_word(it);
		it.cx = 24'sd900; it.cy = -24'sd2100; it.last = 1;
		send_word(it);
		// Sums clear after a last word; held query stays
		it.last = 0; it.cx = 24'sd1000 - RADIUS_RESET; it.cy = -24'sd2000;
		send_word(it);
		it.last = 1; it.qx = 24'sh7FFFFF;
		send_word(it);
		// Kept only on the edge: zero total weight
		it.first = 1; it.qx = 24'sd0; it.qy = 24'sd0; it.qz = 24'sd0;
		it.cx = -RADIUS_RESET; it.cy = 24'sd0; it.cz = 24'sd0;
		send_word(it);
		run_query(3);
		drain();

		// Widest radius: most candidates kept
		write_radius(24'hFFFFFF);
		run_random(100);
		drain();

		// Narrowest radius
		write_radius(24'd1);
		run_random(80);
		drain();

		// Mid radius with the result side held off while words keep coming
		write_radius(24'($urandom_range(1000, 200000)));
		calm = 1;
		hold_req = 1;
		for (int i = 0; i < 12; i++) run_query($urandom_range(1, 2));
		calm = 0;
		run_random(120);
		drain();

		write_radius(RADIUS_RESET);
		run_random(100);
		drain();

		if (pred.errors == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule
